>>> hw/rtl/twie_pkg.sv
// Shared types and constants for the two-wire bus event engine.
package twie_pkg;

    // Command codes carried on the func field.
    typedef enum logic [2:0] {
        FN_EVENT   = 3'd0,
        FN_LOAD    = 3'd1,
        FN_START   = 3'd2,
        FN_ARM     = 3'd3,
        FN_READ    = 3'd4,
        FN_RELEASE = 3'd5
    } t_func;

    // Controller states.
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic execute;
    } t_ctl_cmd;

    // Control words written to the bus unit, the empty error status and the fill byte.
    localparam logic [7:0] CW_RUN   = 8'h85;
    localparam logic [7:0] CW_STOP  = 8'h95;
    localparam logic [7:0] CW_START = 8'hA5;
    localparam logic [7:0] CW_SLAVE = 8'hC5;
    localparam logic [7:0] CW_NOACK = 8'h81;
    localparam logic [7:0] CW_RECOV = 8'h90;
    localparam logic [7:0] ERR_NONE = 8'hF8;
    localparam logic [7:0] FILL_BYTE = 8'hFF;

    // Bus status codes.
    localparam logic [7:0] BS_START      = 8'h08;
    localparam logic [7:0] BS_REP_START  = 8'h10;
    localparam logic [7:0] BS_MT_SLA_ACK = 8'h18;
    localparam logic [7:0] BS_MT_SLA_NAK = 8'h20;
    localparam logic [7:0] BS_MT_DAT_ACK = 8'h28;
    localparam logic [7:0] BS_MT_DAT_NAK = 8'h30;
    localparam logic [7:0] BS_ARB_LOST   = 8'h38;
    localparam logic [7:0] BS_SR_SLA_ACK = 8'h60;
    localparam logic [7:0] BS_SR_ARB_SLA = 8'h68;
    localparam logic [7:0] BS_SR_GC_ACK  = 8'h70;
    localparam logic [7:0] BS_SR_ARB_GC  = 8'h78;
    localparam logic [7:0] BS_SR_DAT_ACK = 8'h80;
    localparam logic [7:0] BS_SR_DAT_NAK = 8'h88;
    localparam logic [7:0] BS_SR_GC_DAT  = 8'h90;
    localparam logic [7:0] BS_SR_GC_NAK  = 8'h98;
    localparam logic [7:0] BS_SR_STOP    = 8'hA0;
    localparam logic [7:0] BS_ST_SLA_ACK = 8'hA8;
    localparam logic [7:0] BS_ST_DAT_ACK = 8'hB8;
    localparam logic [7:0] BS_ST_DAT_NAK = 8'hC0;
    localparam logic [7:0] BS_ST_LAST    = 8'hC8;
    localparam logic [7:0] BS_NO_INFO    = 8'hF8;
    localparam logic [7:0] BS_BUS_ERROR  = 8'h00;

    // Bit positions in the status flags.
    localparam int FL_OK     = 0;
    localparam int FL_GEN    = 1;
    localparam int FL_MASTER = 2;
    localparam int FL_RXBUF  = 3;

endpackage

>>> hw/rtl/twie_ram.sv
// Generic single-write, single-read RAM with registered read data.
module twie_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/twie_ctrl.sv
// Controller state machine that sequences capture and execution of one word.
module twie_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    output twie_pkg::t_ctl_cmd o_cmd,
    output logic              o_valid
);
    import twie_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_valid;

    // State and strobe registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == ST_EXEC);
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state       = r_state;
        o_cmd.capture = 1'b0;
        o_cmd.execute = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.execute = 1'b1;
                n_state       = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy    = (r_state == ST_EXEC);
    assign o_valid = r_valid;

endmodule

>>> hw/rtl/twie_datapath.sv
// Datapath: buffers, transfer state and the event decode for one word.
module twie_datapath #(
    parameter int PACKET_BYTES = 16,
    parameter int CNT_W        = $clog2(PACKET_BYTES + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  twie_pkg::t_ctl_cmd i_cmd,
    input  logic [2:0]         i_func,
    input  logic [7:0]         i_status_code,
    input  logic [7:0]         i_data_byte,
    input  logic [3:0]         i_buffer_index,
    input  logic               i_keep_busy,
    output logic [7:0]         o_control_word,
    output logic               o_control_write,
    output logic [7:0]         o_send_byte,
    output logic               o_send_write,
    output logic               o_busy_now,
    output logic [CNT_W-1:0]   o_bytes_available,
    output logic [7:0]         o_read_byte,
    output logic               o_last_ok,
    output logic               o_general_call,
    output logic               o_master_active,
    output logic               o_rx_in_buffer,
    output logic [7:0]         o_error_status
);
    import twie_pkg::*;

    localparam int ADDR_W = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1;
    localparam logic [CNT_W-1:0] PKT_LIMIT = CNT_W'(PACKET_BYTES);

    // Captured word.
    logic [2:0]       r_func;
    logic [7:0]       r_st;
    logic [7:0]       r_data;
    logic [3:0]       r_idx;
    logic             r_keep;

    // Transfer state.
    logic [CNT_W-1:0] r_pos, n_pos;
    logic             r_idle, n_idle;
    logic [CNT_W-1:0] r_rxc, n_rxc;
    logic             r_busy, n_busy;
    logic [7:0]       r_ctl, n_ctl;
    logic [3:0]       r_flags, n_flags;
    logic [7:0]       r_err, n_err;

    // Result registers.
    logic [7:0]       r_o_ctl;
    logic             r_o_cw;
    logic [7:0]       r_o_sb;
    logic             r_o_sw;
    logic             r_o_bn;
    logic [CNT_W-1:0] r_o_avail;
    logic [7:0]       r_o_rd;

    // Step results.
    logic             cw_wr;
    logic             sb_wr;
    logic [7:0]       sb_val;
    logic [7:0]       rd_val;
    logic             bn_before;
    logic             bn_after;
    logic             tx_avail;
    logic             idx_ok;

    // Buffer ports.
    logic             pos_rst;
    logic [ADDR_W-1:0] tx_raddr;
    logic [7:0]       tx_rdata;
    logic             tx_we;
    logic [7:0]       rx_rdata;
    logic             rx_we;

    // A start, repeated start or slave-transmit address rewinds the position
    // before the first byte is fetched.
    assign pos_rst = (t_func'(i_func) == FN_EVENT) &&
                     ((i_status_code == BS_START) || (i_status_code == BS_REP_START) ||
                      (i_status_code == BS_ST_SLA_ACK));
    assign tx_raddr = pos_rst ? '0 : ADDR_W'(r_pos);

    twie_ram #(
        .WIDTH (8),
        .DEPTH (PACKET_BYTES)
    ) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (tx_we),
        .i_waddr (ADDR_W'(r_idx)),
        .i_wdata (r_data),
        .i_raddr (tx_raddr),
        .o_rdata (tx_rdata)
    );

    twie_ram #(
        .WIDTH (8),
        .DEPTH (PACKET_BYTES)
    ) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (rx_we),
        .i_waddr (ADDR_W'(r_rxc)),
        .i_wdata (r_data),
        .i_raddr (ADDR_W'(i_buffer_index)),
        .o_rdata (rx_rdata)
    );

    assign bn_before = r_busy | r_ctl[0];
    assign tx_avail  = !r_idle && (r_pos < PKT_LIMIT);
    assign idx_ok    = (32'(r_idx) < 32'(PACKET_BYTES));

    // Decode of one word into the next state and the result.
    // Buffer writes happen only on the execute cycle of the word.
    always_comb begin
        n_pos   = r_pos;
        n_idle  = r_idle;
        n_rxc   = r_rxc;
        n_busy  = r_busy;
        n_ctl   = r_ctl;
        n_flags = r_flags;
        n_err   = r_err;
        cw_wr   = 1'b0;
        sb_wr   = 1'b0;
        sb_val  = '0;
        rd_val  = '0;
        tx_we   = 1'b0;
        rx_we   = 1'b0;
        case (t_func'(r_func))
            FN_EVENT: begin
                case (r_st)
                    BS_START, BS_REP_START: begin
                        n_idle = 1'b0;
                        sb_wr  = 1'b1;
                        sb_val = tx_rdata;
                        n_pos  = CNT_W'(1);
                        n_ctl  = CW_RUN;
                        cw_wr  = 1'b1;
                        n_busy = 1'b1;
                    end
                    BS_MT_SLA_ACK, BS_MT_SLA_NAK, BS_MT_DAT_ACK, BS_MT_DAT_NAK: begin
                        sb_wr = 1'b1;
                        cw_wr = 1'b1;
                        if (tx_avail) begin
                            sb_val = tx_rdata;
                            n_pos  = CNT_W'(r_pos + CNT_W'(1));
                            n_ctl  = CW_RUN;
                            n_busy = 1'b1;
                        end else begin
                            n_idle = 1'b1;
                            sb_val = FILL_BYTE;
                            n_ctl  = CW_STOP;
                            n_busy = 1'b0;
                            n_flags[FL_MASTER] = 1'b0;
                        end
                    end
                    BS_ARB_LOST: begin
                        n_pos  = '0;
                        n_idle = 1'b0;
                        n_ctl  = CW_START;
                        cw_wr  = 1'b1;
                        n_busy = 1'b1;
                    end
                    BS_ST_DAT_NAK: begin
                        if (r_idle) begin
                            n_flags[FL_OK] = 1'b1;
                        end else begin
                            n_err = r_st;
                        end
                        n_ctl  = CW_SLAVE;
                        cw_wr  = 1'b1;
                        n_busy = 1'b0;
                    end
                    BS_ST_SLA_ACK: begin
                        n_idle = 1'b0;
                        sb_wr  = 1'b1;
                        sb_val = tx_rdata;
                        n_pos  = CNT_W'(1);
                        n_ctl  = CW_SLAVE;
                        cw_wr  = 1'b1;
                        n_busy = 1'b1;
                    end
                    BS_ST_DAT_ACK: begin
                        sb_wr = 1'b1;
                        if (tx_avail) begin
                            sb_val = tx_rdata;
                            n_pos  = CNT_W'(r_pos + CNT_W'(1));
                        end else begin
                            sb_val = FILL_BYTE;
                        end
                        n_ctl  = CW_SLAVE;
                        cw_wr  = 1'b1;
                        n_busy = 1'b1;
                    end
                    BS_SR_ARB_SLA: begin
                        n_flags[FL_GEN] = 1'b0;
                    end
                    BS_SR_GC_ACK, BS_SR_SLA_ACK: begin
                        if (r_st == BS_SR_GC_ACK) begin
                            n_flags[FL_GEN] = 1'b1;
                        end
                        n_flags[FL_RXBUF] = 1'b1;
                        n_pos  = '0;
                        n_idle = 1'b0;
                        n_ctl  = CW_SLAVE;
                        cw_wr  = 1'b1;
                        n_busy = 1'b1;
                    end
                    BS_SR_DAT_ACK, BS_SR_GC_DAT: begin
                        // A full buffer drops the byte and answers with no ACK.
                        if (r_rxc < PKT_LIMIT) begin
                            rx_we = i_cmd.execute;
                            n_rxc = CNT_W'(r_rxc + CNT_W'(1));
                            n_ctl = CW_SLAVE;
                        end else begin
                            n_ctl = CW_NOACK;
                        end
                        cw_wr  = 1'b1;
                        n_busy = 1'b1;
                        n_flags[FL_OK] = 1'b1;
                    end
                    BS_SR_STOP: begin
                        n_ctl  = CW_SLAVE;
                        cw_wr  = 1'b1;
                        n_busy = 1'b0;
                    end
                    BS_SR_ARB_GC, BS_NO_INFO, BS_SR_DAT_NAK, BS_SR_GC_NAK,
                    BS_ST_LAST, BS_BUS_ERROR: begin
                        n_err = r_st;
                        n_ctl = CW_RECOV;
                        cw_wr = 1'b1;
                    end
                    default: begin
                        n_err  = r_st;
                        n_ctl  = CW_SLAVE;
                        cw_wr  = 1'b1;
                        n_busy = 1'b0;
                    end
                endcase
            end
            FN_LOAD: begin
                tx_we = i_cmd.execute && r_idle && idx_ok;
            end
            FN_START: begin
                if (r_idle) begin
                    n_pos  = '0;
                    n_idle = 1'b0;
                    if (!r_busy) begin
                        n_ctl = CW_START;
                        cw_wr = 1'b1;
                        n_flags[FL_MASTER] = 1'b1;
                    end
                end
            end
            FN_ARM: begin
                if (!bn_before) begin
                    n_flags = '0;
                    n_err   = ERR_NONE;
                    n_ctl   = CW_SLAVE;
                    cw_wr   = 1'b1;
                    n_busy  = r_keep;
                end
            end
            FN_READ: begin
                if (!bn_before && idx_ok) begin
                    rd_val = rx_rdata;
                end
            end
            FN_RELEASE: begin
                if (!bn_before) begin
                    n_rxc = '0;
                end
            end
            default: begin
            end
        endcase
    end

    assign bn_after = n_busy | n_ctl[0];

    // Capture of the accepted word.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func <= i_func;
            r_st   <= i_status_code;
            r_data <= i_data_byte;
            r_idx  <= i_buffer_index;
            r_keep <= i_keep_busy;
        end
    end

    // Transfer state update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_idle  <= 1'b1;
            r_rxc   <= '0;
            r_busy  <= 1'b0;
            r_ctl   <= '0;
            r_flags <= '0;
            r_err   <= ERR_NONE;
        end else if (i_cmd.execute) begin
            r_pos   <= n_pos;
            r_idle  <= n_idle;
            r_rxc   <= n_rxc;
            r_busy  <= n_busy;
            r_ctl   <= n_ctl;
            r_flags <= n_flags;
            r_err   <= n_err;
        end
    end

    // Result registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            r_o_ctl   <= n_ctl;
            r_o_cw    <= cw_wr;
            r_o_sb    <= sb_val;
            r_o_sw    <= sb_wr;
            r_o_bn    <= bn_after;
            r_o_avail <= bn_after ? n_rxc : '0;
            r_o_rd    <= rd_val;
        end
    end

    assign o_control_word    = r_o_ctl;
    assign o_control_write   = r_o_cw;
    assign o_send_byte       = r_o_sb;
    assign o_send_write      = r_o_sw;
    assign o_busy_now        = r_o_bn;
    assign o_bytes_available = r_o_avail;
    assign o_read_byte       = r_o_rd;
    assign o_last_ok         = r_flags[FL_OK];
    assign o_general_call    = r_flags[FL_GEN];
    assign o_master_active   = r_flags[FL_MASTER];
    assign o_rx_in_buffer    = r_flags[FL_RXBUF];
    assign o_error_status    = r_err;

endmodule

>>> hw/rtl/twi_master_slave_event_engine.sv
// Top level of the two-wire bus event engine for master-transmit and slave roles.
//
// Each word is taken when start is high and busy is low; the transmit and
// receive buffer RAMs are read at that edge, and the next cycle decodes the
// word and updates the state. The result then stands on the o_ ports for one
// cycle marked by o_valid, while busy is already low again, so a new word may
// be issued while the result stands. The receiver cannot stall: a result not
// taken in its cycle is gone. Buffer entries that were never written read back
// as unknown values.
module twi_master_slave_event_engine #(
    parameter int PACKET_BYTES = 16,
    parameter int CNT_W        = $clog2(PACKET_BYTES + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [2:0]       i_func,
    input  logic [7:0]       i_status_code,
    input  logic [7:0]       i_data_byte,
    input  logic [3:0]       i_buffer_index,
    input  logic             i_keep_busy,
    output logic             o_valid,
    output logic [7:0]       o_control_word,
    output logic             o_control_write,
    output logic [7:0]       o_send_byte,
    output logic             o_send_write,
    output logic             o_busy_now,
    output logic [CNT_W-1:0] o_bytes_available,
    output logic [7:0]       o_read_byte,
    output logic             o_last_ok,
    output logic             o_general_call,
    output logic             o_master_active,
    output logic             o_rx_in_buffer,
    output logic [7:0]       o_error_status
);
    import twie_pkg::*;

    t_ctl_cmd cmd;

    // Sequencing of capture and execution.
    twie_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (cmd),
        .o_valid (o_valid)
    );

    // Buffers, transfer state and decode.
    twie_datapath #(
        .PACKET_BYTES (PACKET_BYTES),
        .CNT_W        (CNT_W)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_func            (i_func),
        .i_status_code     (i_status_code),
        .i_data_byte       (i_data_byte),
        .i_buffer_index    (i_buffer_index),
        .i_keep_busy       (i_keep_busy),
        .o_control_word    (o_control_word),
        .o_control_write   (o_control_write),
        .o_send_byte       (o_send_byte),
        .o_send_write      (o_send_write),
        .o_busy_now        (o_busy_now),
        .o_bytes_available (o_bytes_available),
        .o_read_byte       (o_read_byte),
        .o_last_ok         (o_last_ok),
        .o_general_call    (o_general_call),
        .o_master_active   (o_master_active),
        .o_rx_in_buffer    (o_rx_in_buffer),
        .o_error_status    (o_error_status)
    );

endmodule

>>> sim/twi_master_slave_event_engine_tb.sv
// Self-checking testbench for the two-wire bus event engine: directed words, then random bus scenarios.
`timescale 1ns / 100ps

module twi_master_slave_event_engine_tb;
    import twie_pkg::*;

    localparam int PACKET_BYTES = 16;
    localparam int CNT_W        = $clog2(PACKET_BYTES + 1);
    localparam int RANDOM_WORDS = 1600;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 8;
    localparam int DIR_ROWS     = 28;

    // Codes 6 and 7 of the func field have no meaning in the block.
    localparam logic [2:0] FN_SPARE6 = 3'd6;
    localparam logic [2:0] FN_SPARE7 = 3'd7;

    // Status codes that put the bus unit into recovery without touching busy.
    localparam logic [7:0] RECOV_CODES [6] = '{
        BS_SR_ARB_GC, BS_NO_INFO, BS_SR_DAT_NAK, BS_SR_GC_NAK, BS_ST_LAST, BS_BUS_ERROR
    };

    // One result word as the block reports it.
    typedef struct packed {
        logic [7:0]       control_word;
        logic             control_write;
        logic [7:0]       send_byte;
        logic             send_write;
        logic             busy_now;
        logic [CNT_W-1:0] bytes_available;
        logic [7:0]       read_byte;
        logic             last_ok;
        logic             general_call;
        logic             master_active;
        logic             rx_in_buffer;
        logic [7:0]       error_status;
    } t_bus_result;

    // One directed word, with its result typed in where it is obvious.
    typedef struct {
        logic [2:0]  fn;
        logic [7:0]  st;
        logic [7:0]  dat;
        logic [3:0]  ix;
        logic        kb;
        bit          typed;
        t_bus_result want;
    } t_dir_row;

    logic             i_clk;
    logic             i_rst_n        = 1'b0;
    logic             start          = 1'b0;
    logic             busy;
    logic [2:0]       i_func         = '0;
    logic [7:0]       i_status_code  = '0;
    logic [7:0]       i_data_byte    = '0;
    logic [3:0]       i_buffer_index = '0;
    logic             i_keep_busy    = 1'b0;
    logic             o_valid;
    logic [7:0]       o_control_word;
    logic             o_control_write;
    logic [7:0]       o_send_byte;
    logic             o_send_write;
    logic             o_busy_now;
    logic [CNT_W-1:0] o_bytes_available;
    logic [7:0]       o_read_byte;
    logic             o_last_ok;
    logic             o_general_call;
    logic             o_master_active;
    logic             o_rx_in_buffer;
    logic [7:0]       o_error_status;

    // Mirror of the engine state.
    logic [7:0] tx_mem [PACKET_BYTES];
    logic [7:0] rx_mem [PACKET_BYTES];
    logic [PACKET_BYTES-1:0] rx_seen = '0;
    logic [4:0] tx_ptr    = '0;
    logic       tx_free   = 1'b1;
    logic [4:0] rx_fill   = '0;
    logic       hold_busy = 1'b0;
    logic [7:0] ctl_reg   = '0;
    logic [3:0] flag_reg  = '0;
    logic [7:0] err_reg   = ERR_NONE;

    // Side outputs of the current prediction step.
    logic       step_cw_wr;
    logic       step_sb_wr;
    logic [7:0] step_sb;

    t_bus_result expected_q [$];
    t_bus_result got_want;
    t_dir_row    dir_rows [DIR_ROWS];
    int          fail_count  = 0;
    int          random_done = 0;
    int          stall_count = 0;
    bit          steady      = 1'b0;

    twi_master_slave_event_engine #(
        .PACKET_BYTES(PACKET_BYTES)
    ) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_func           (i_func),
        .i_status_code    (i_status_code),
        .i_data_byte      (i_data_byte),
        .i_buffer_index   (i_buffer_index),
        .i_keep_busy      (i_keep_busy),
        .o_valid          (o_valid),
        .o_control_word   (o_control_word),
        .o_control_write  (o_control_write),
        .o_send_byte      (o_send_byte),
        .o_send_write     (o_send_write),
        .o_busy_now       (o_busy_now),
        .o_bytes_available(o_bytes_available),
        .o_read_byte      (o_read_byte),
        .o_last_ok        (o_last_ok),
        .o_general_call   (o_general_call),
        .o_master_active  (o_master_active),
        .o_rx_in_buffer   (o_rx_in_buffer),
        .o_error_status   (o_error_status)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // The engine counts as busy while it holds the bus or the interrupt enable is set.
    function automatic logic engine_busy();
        return hold_busy | ctl_reg[0];
    endfunction

    task automatic emit_control(input logic [7:0] v);
        ctl_reg    = v;
        step_cw_wr = 1'b1;
    endtask

    task automatic emit_send(input logic [7:0] v);
        step_sb    = v;
        step_sb_wr = 1'b1;
    endtask

    // Next master byte, or a stop once the packet is out.
    task automatic master_advance();
        if (!tx_free && tx_ptr < PACKET_BYTES) begin
            emit_send(tx_mem[tx_ptr[3:0]]);
            tx_ptr = tx_ptr + 1'b1;
            emit_control(CW_RUN);
            hold_busy = 1'b1;
        end else begin
            tx_free = 1'b1;
            emit_send(FILL_BYTE);
            emit_control(CW_STOP);
            hold_busy = 1'b0;
            flag_reg[FL_MASTER] = 1'b0;
        end
    endtask

    // Next slave byte; the fill byte goes out once the packet is exhausted.
    task automatic slave_advance();
        if (!tx_free && tx_ptr < PACKET_BYTES) begin
            emit_send(tx_mem[tx_ptr[3:0]]);
            tx_ptr = tx_ptr + 1'b1;
        end else begin
            emit_send(FILL_BYTE);
        end
        emit_control(CW_SLAVE);
        hold_busy = 1'b1;
    endtask

    // Reaction to one bus status code.
    task automatic bus_step(input logic [7:0] st, input logic [7:0] dat);
        case (st)
            BS_START, BS_REP_START: begin
                tx_ptr  = '0;
                tx_free = 1'b0;
                master_advance();
            end
            BS_MT_SLA_ACK, BS_MT_SLA_NAK, BS_MT_DAT_ACK, BS_MT_DAT_NAK: master_advance();
            BS_ARB_LOST: begin
                tx_ptr  = '0;
                tx_free = 1'b0;
                emit_control(CW_START);
                hold_busy = 1'b1;
            end
            BS_ST_DAT_NAK: begin
                if (tx_free) flag_reg[FL_OK] = 1'b1;
                else err_reg = st;
                emit_control(CW_SLAVE);
                hold_busy = 1'b0;
            end
            BS_ST_SLA_ACK: begin
                tx_ptr  = '0;
                tx_free = 1'b0;
                slave_advance();
            end
            BS_ST_DAT_ACK: slave_advance();
            BS_SR_ARB_SLA: flag_reg[FL_GEN] = 1'b0;
            BS_SR_GC_ACK, BS_SR_SLA_ACK: begin
                if (st == BS_SR_GC_ACK) flag_reg[FL_GEN] = 1'b1;
                flag_reg[FL_RXBUF] = 1'b1;
                tx_ptr  = '0;
                tx_free = 1'b0;
                emit_control(CW_SLAVE);
                hold_busy = 1'b1;
            end
            BS_SR_DAT_ACK, BS_SR_GC_DAT: begin
                // A full receive buffer drops the byte and answers without ACK.
                if (rx_fill < PACKET_BYTES) begin
                    rx_mem[rx_fill[3:0]]  = dat;
                    rx_seen[rx_fill[3:0]] = 1'b1;
                    rx_fill = rx_fill + 1'b1;
                    emit_control(CW_SLAVE);
                end else begin
                    emit_control(CW_NOACK);
                end
                hold_busy = 1'b1;
                flag_reg[FL_OK] = 1'b1;
            end
            BS_SR_STOP: begin
                emit_control(CW_SLAVE);
                hold_busy = 1'b0;
            end
            BS_SR_ARB_GC, BS_NO_INFO, BS_SR_DAT_NAK, BS_SR_GC_NAK, BS_ST_LAST,
            BS_BUS_ERROR: begin
                err_reg = st;
                emit_control(CW_RECOV);
            end
            default: begin
                // Unknown codes are kept as the error and release the bus.
                err_reg = st;
                emit_control(CW_SLAVE);
                hold_busy = 1'b0;
            end
        endcase
    endtask

    // Advances the mirror by one word and forms the expected result.
    task automatic predict_word(input logic [2:0] fn, input logic [7:0] st,
                                input logic [7:0] dat, input logic [3:0] ix,
                                input logic kb, output t_bus_result r, output bit acted);
        logic [7:0] rd;
        logic       bn;
        rd         = 8'h00;
        step_cw_wr = 1'b0;
        step_sb_wr = 1'b0;
        step_sb    = 8'h00;
        acted      = 1'b1;
        case (fn)
            FN_EVENT: bus_step(st, dat);
            FN_LOAD: begin
                if (tx_free) tx_mem[ix] = dat;
                else acted = 1'b0;
            end
            FN_START: begin
                // A start during an active bus hold only rearms the position.
                if (tx_free) begin
                    tx_ptr  = '0;
                    tx_free = 1'b0;
                    if (!hold_busy) begin
                        emit_control(CW_START);
                        flag_reg[FL_MASTER] = 1'b1;
                    end
                end else begin
                    acted = 1'b0;
                end
            end
            FN_ARM: begin
                if (!engine_busy()) begin
                    flag_reg = '0;
                    err_reg  = ERR_NONE;
                    emit_control(CW_SLAVE);
                    hold_busy = kb;
                end else begin
                    acted = 1'b0;
                end
            end
            FN_READ: begin
                if (!engine_busy()) rd = rx_mem[ix];
                else acted = 1'b0;
            end
            FN_RELEASE: begin
                if (!engine_busy()) rx_fill = '0;
                else acted = 1'b0;
            end
            default: acted = 1'b0;
        endcase
        bn = engine_busy();
        r.control_word    = ctl_reg;
        r.control_write   = step_cw_wr;
        r.send_byte       = step_sb_wr ? step_sb : 8'h00;
        r.send_write      = step_sb_wr;
        r.busy_now        = bn;
        r.bytes_available = bn ? rx_fill[CNT_W-1:0] : '0;
        r.read_byte       = rd;
        r.last_ok         = flag_reg[FL_OK];
        r.general_call    = flag_reg[FL_GEN];
        r.master_active   = flag_reg[FL_MASTER];
        r.rx_in_buffer    = flag_reg[FL_RXBUF];
        r.error_status    = err_reg;
    endtask

    // Drives one word until the engine takes it, then records what it must answer.
    task automatic issue(input logic [2:0] fn, input logic [7:0] st, input logic [7:0] dat,
                         input logic [3:0] ix, input logic kb,
                         input bit typed = 1'b0, input t_bus_result want = '0);
        t_bus_result r;
        bit          acted;
        // A granted read must only hit receive entries that were filled.
        if (fn == FN_READ && !engine_busy() && !rx_seen[ix]) begin
            if (rx_seen == '0) fn = FN_RELEASE;
            else while (!rx_seen[ix]) ix = ix + 1'b1;
        end
        while (!steady && $urandom_range(99) < 33) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start          <= 1'b1;
        i_func         <= fn;
        i_status_code  <= st;
        i_data_byte    <= dat;
        i_buffer_index <= ix;
        i_keep_busy    <= kb;
        do @(posedge i_clk); while (busy);
        predict_word(fn, st, dat, ix, kb, r, acted);
        expected_q.push_back(typed ? want : r);
        if (acted) random_done++;
    endtask

    task automatic bus_ev(input logic [7:0] st);
        issue(FN_EVENT, st, 8'($urandom_range(255)), 4'($urandom_range(15)),
              1'($urandom_range(1)));
    endtask

    task automatic cmd(input logic [2:0] fn);
        issue(fn, 8'($urandom_range(255)), 8'($urandom_range(255)), 4'($urandom_range(15)),
              1'($urandom_range(1)));
    endtask

    // Stop, then a recovery code, leaves the engine not busy and open to arm, read and release.
    task automatic free_bus();
        bus_ev(BS_SR_STOP);
        bus_ev(RECOV_CODES[$urandom_range(5)]);
    endtask

    // One random bus scenario: master send, slave receive, slave send or noise.
    task automatic run_scenario();
        int kind;
        int n;
        kind = $urandom_range(99);
        if (kind < 30) begin
            repeat ($urandom_range(3)) cmd(FN_LOAD);
            if ($urandom_range(3) == 0) bus_ev(BS_SR_DAT_ACK);
            cmd(FN_START);
            bus_ev($urandom_range(1) ? BS_START : BS_REP_START);
            n = ($urandom_range(3) == 0) ? $urandom_range(1, 18) : 17;
            repeat (n) begin
                case ($urandom_range(39))
                    0:       bus_ev(BS_ARB_LOST);
                    1:       bus_ev(BS_REP_START);
                    2, 3, 4, 5:     bus_ev(BS_MT_SLA_ACK);
                    6, 7, 8, 9:     bus_ev(BS_MT_SLA_NAK);
                    10, 11, 12, 13: bus_ev(BS_MT_DAT_NAK);
                    default: bus_ev(BS_MT_DAT_ACK);
                endcase
            end
        end else if (kind < 60) begin
            free_bus();
            cmd(FN_ARM);
            bus_ev($urandom_range(1) ? BS_SR_SLA_ACK : BS_SR_GC_ACK);
            n = ($urandom_range(4) == 0) ? $urandom_range(16, 20) : $urandom_range(1, 15);
            repeat (n) bus_ev($urandom_range(1) ? BS_SR_DAT_ACK : BS_SR_GC_DAT);
            if ($urandom_range(3) == 0) bus_ev(BS_SR_ARB_SLA);
            free_bus();
            repeat ($urandom_range(1, 4)) cmd(FN_READ);
            if ($urandom_range(1)) cmd(FN_RELEASE);
        end else if (kind < 85) begin
            free_bus();
            cmd(FN_ARM);
            if ($urandom_range(3) != 0) bus_ev(BS_ST_SLA_ACK);
            repeat ($urandom_range(20)) bus_ev(BS_ST_DAT_ACK);
            bus_ev(BS_ST_DAT_NAK);
        end else begin
            // Any func code with status codes on the standard grid or anywhere.
            repeat ($urandom_range(1, 4))
                issue(3'($urandom_range(7)),
                      $urandom_range(1) ? 8'($urandom_range(255))
                                        : {5'($urandom_range(31)), 3'b000},
                      8'($urandom_range(255)), 4'($urandom_range(15)),
                      1'($urandom_range(1)));
        end
    endtask

    // Compare one field of the result word.
    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%02h, actual 0x%02h", name, want, got);
            fail_count++;
        end
    endfunction

    // Result checker: every strobed word must match the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (expected_q.size() == 0) begin
                $error("result word with no expectation pending");
                fail_count++;
            end else begin
                got_want = expected_q.pop_front();
                check_field("control_word", got_want.control_word, o_control_word);
                check_field("control_write", got_want.control_write, o_control_write);
                check_field("send_byte", got_want.send_byte, o_send_byte);
                check_field("send_write", got_want.send_write, o_send_write);
                check_field("busy_now", got_want.busy_now, o_busy_now);
                check_field("bytes_available", got_want.bytes_available, o_bytes_available);
                check_field("read_byte", got_want.read_byte, o_read_byte);
                check_field("last_ok", got_want.last_ok, o_last_ok);
                check_field("general_call", got_want.general_call, o_general_call);
                check_field("master_active", got_want.master_active, o_master_active);
                check_field("rx_in_buffer", got_want.rx_in_buffer, o_rx_in_buffer);
                check_field("error_status", got_want.error_status, o_error_status);
            end
        end
    end

    // Watchdog on cycles in which no word moves either way.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_valid) stall_count <= 0;
            else stall_count <= stall_count + 1;
            if (stall_count >= STALL_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Stimulus.
    initial begin
        dir_rows = '{
            // Spare code after reset and the buffer fill reports the reset state.
            '{FN_SPARE7, 8'h00, 8'h00, 4'd0, 1'b0, 1'b1,
              '{8'h00, 1'b0, 8'h00, 1'b0, 1'b0, '0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, ERR_NONE}},
            '{FN_LOAD,    8'h00, 8'h00, 4'd0,  1'b0, 1'b0, '0},
            '{FN_LOAD,    8'hFF, 8'hFF, 4'd15, 1'b1, 1'b0, '0},
            '{FN_START,   8'h00, 8'h00, 4'd0,  1'b0, 1'b0, '0},
            // Load and start while a send is open are ignored.
            '{FN_LOAD,    8'h00, 8'h5A, 4'd1,  1'b0, 1'b0, '0},
            '{FN_START,   8'h00, 8'h00, 4'd0,  1'b0, 1'b0, '0},
            '{FN_EVENT,   BS_START,      8'h00, 4'd0, 1'b0, 1'b0, '0},
            '{FN_EVENT,   BS_MT_SLA_ACK, 8'hFF, 4'd0, 1'b0, 1'b0, '0},
            // Arm, read and release while busy are ignored.
            '{FN_ARM,     8'h00, 8'h00, 4'd0,  1'b1, 1'b0, '0},
            '{FN_READ,    8'h00, 8'h00, 4'd3,  1'b0, 1'b0, '0},
            '{FN_RELEASE, 8'h00, 8'h00, 4'd0,  1'b0, 1'b0, '0},
            '{FN_EVENT,   BS_ARB_LOST,   8'h00, 4'd0, 1'b0, 1'b0, '0},
            '{FN_EVENT,   BS_SR_STOP,    8'h00, 4'd0, 1'b0, 1'b0, '0},
            '{FN_EVENT,   BS_SR_DAT_NAK, 8'h00, 4'd0, 1'b0, 1'b0, '0},
            '{FN_ARM,     8'h00, 8'h00, 4'd0,  1'b0, 1'b1,
              '{CW_SLAVE, 1'b1, 8'h00, 1'b0, 1'b1, '0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, ERR_NONE}},
            '{FN_EVENT,   BS_SR_GC_ACK,  8'h00, 4'd0, 1'b0, 1'b0, '0},
            '{FN_EVENT,   BS_SR_GC_DAT,  8'h00, 4'd0, 1'b0, 1'b0, '0},
            '{FN_EVENT,   BS_SR_DAT_ACK, 8'hFF, 4'd0, 1'b0, 1'b0, '0},
            '{FN_EVENT,   BS_SR_ARB_SLA, 8'h00, 4'd0, 1'b0, 1'b0, '0},
            '{FN_EVENT,   BS_SR_STOP,    8'h00, 4'd0, 1'b0, 1'b0, '0},
            '{FN_EVENT,   BS_BUS_ERROR,  8'h00, 4'd0, 1'b0, 1'b0, '0},
            '{FN_READ,    8'h00, 8'h00, 4'd1,  1'b0, 1'b0, '0},
            '{FN_RELEASE, 8'h00, 8'h00, 4'd0,  1'b0, 1'b0, '0},
            '{FN_ARM,     8'h00, 8'h00, 4'd0,  1'b1, 1'b0, '0},
            '{FN_EVENT,   BS_ST_SLA_ACK, 8'h00, 4'd0, 1'b0, 1'b0, '0},
            '{FN_EVENT,   BS_ST_DAT_NAK, 8'h00, 4'd0, 1'b0, 1'b0, '0},
            // An unknown status code is stored as the error.
            '{FN_EVENT,   8'h01, 8'h00, 4'd0, 1'b0, 1'b1,
              '{CW_SLAVE, 1'b1, 8'h00, 1'b0, 1'b1, '0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 8'h01}},
            '{FN_SPARE6,  8'hFF, 8'hFF, 4'd15, 1'b1, 1'b0, '0}
        };

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Fill the whole transmit buffer so that no send reads an unwritten entry.
        for (int k = 0; k < PACKET_BYTES; k++)
            issue(FN_LOAD, 8'($urandom_range(255)), 8'($urandom_range(255)), 4'(k),
                  1'($urandom_range(1)));

        foreach (dir_rows[k])
            issue(dir_rows[k].fn, dir_rows[k].st, dir_rows[k].dat, dir_rows[k].ix,
                  dir_rows[k].kb, dir_rows[k].typed, dir_rows[k].want);

        // Random scenarios, with one long stretch where the sender never pauses.
        random_done = 0;
        while (random_done < RANDOM_WORDS) begin
            steady = (random_done >= 700 && random_done < 1000);
            run_scenario();
        end
        start <= 1'b0;

        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/twie_pkg.sv
hw/rtl/twie_ram.sv
hw/rtl/twie_ctrl.sv
hw/rtl/twie_datapath.sv
hw/rtl/twi_master_slave_event_engine.sv
sim/twi_master_slave_event_engine_tb.sv
